// ===== hw/rtl/keypad_alarm_controller_defines.svh =====
// Assertion macros for the keypad alarm controller.
`ifndef KEYPAD_ALARM_CONTROLLER_DEFINES_SVH
`define KEYPAD_ALARM_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define KAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define KAC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define KAC_ASSERT(label, prop, msg)
`define KAC_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== hw/rtl/kac_pkg.sv =====
package kac_pkg;

    localparam int ADDR_W = 4;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_MOTION = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [7:0] KEY_ENTER = 8'h23;
    localparam logic [7:0] KEY_DEL   = 8'h2A;
    localparam logic [7:0] KEY_REARM = 8'h41;
    localparam logic [7:0] KEY_OFF   = 8'h42;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_WRONG    = 3'd1;
    localparam logic [2:0] EV_OK       = 3'd2;
    localparam logic [2:0] EV_ALARM    = 3'd3;
    localparam logic [2:0] EV_MOTION   = 3'd4;
    localparam logic [2:0] EV_ARMED    = 3'd5;
    localparam logic [2:0] EV_SHUTDOWN = 3'd6;

    localparam logic [2:0] MODE_CODE_ARMED  = 3'd0;
    localparam logic [2:0] MODE_CODE_ENTRY  = 3'd1;
    localparam logic [2:0] MODE_CODE_PROMPT = 3'd2;
    localparam logic [2:0] MODE_CODE_COUNT  = 3'd3;
    localparam logic [2:0] MODE_CODE_OFF    = 3'd4;

    localparam logic [1:0] REG_PIN     = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_REARM   = 2'd2;

    localparam logic [31:0] PIN_RESET     = 32'd825373492;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd10;
    localparam logic [3:0]  REARM_RESET   = 4'd5;

    typedef enum logic [4:0] {
        MODE_ARMED  = 5'b00001,
        MODE_ENTRY  = 5'b00010,
        MODE_PROMPT = 5'b00100,
        MODE_COUNT  = 5'b01000,
        MODE_OFF    = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [31:0] pin_code;
        logic [7:0]  timeout_seconds;
        logic [3:0]  rearm_seconds;
    } t_cfg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] key_code;
    } t_item;

    typedef struct packed {
        logic [2:0] mode;
        logic       buzzer_on;
        logic [2:0] entered_count;
        logic [3:0] countdown_left;
        logic [2:0] event_res;
    } t_res;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_ARMED:  c = MODE_CODE_ARMED;
            MODE_ENTRY:  c = MODE_CODE_ENTRY;
            MODE_PROMPT: c = MODE_CODE_PROMPT;
            MODE_COUNT:  c = MODE_CODE_COUNT;
            MODE_OFF:    c = MODE_CODE_OFF;
            default:     c = MODE_CODE_OFF;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/kac_cfg.sv =====
module kac_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [kac_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output kac_pkg::t_cfg             o_cfg
);
    import kac_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_code        <= PIN_RESET;
            r_cfg.timeout_seconds <= TIMEOUT_RESET;
            r_cfg.rearm_seconds   <= REARM_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PIN:     r_cfg.pin_code        <= pwdata;
                REG_TIMEOUT: r_cfg.timeout_seconds <= pwdata[7:0];
                REG_REARM:   r_cfg.rearm_seconds   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PIN:     prdata = r_cfg.pin_code;
            REG_TIMEOUT: prdata = {24'd0, r_cfg.timeout_seconds};
            REG_REARM:   prdata = {28'd0, r_cfg.rearm_seconds};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/kac_fsm.sv =====
`include "keypad_alarm_controller_defines.svh"

module kac_fsm #(
    parameter int PIN_DIGITS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kac_pkg::t_cfg  i_cfg,
    input  kac_pkg::t_item i_item,
    input  logic           i_adv,
    output kac_pkg::t_res  o_res
);
    import kac_pkg::*;

    localparam int LEN_W = $clog2(PIN_DIGITS + 1);
    localparam int IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

    t_mode            r_mode, n_mode;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_tcnt, n_tcnt;
    logic             r_run, n_run;
    logic             r_buzz, n_buzz;
    logic [3:0]       r_cnt, n_cnt;
    logic [7:0]       r_buf [PIN_DIGITS];

    logic [7:0]       w_pin [PIN_DIGITS];
    logic             w_match;
    logic             w_buf_we;
    logic [IDX_W-1:0] w_buf_idx;
    logic [7:0]       w_tinc;
    logic [3:0]       w_cdec;
    logic [2:0]       w_ev;

    for (genvar g = 0; g < PIN_DIGITS; g++) begin : g_pin
        if (8 * (PIN_DIGITS - 1 - g) < 32) begin : g_in
            assign w_pin[g] = i_cfg.pin_code[8*(PIN_DIGITS-1-g) +: 8];
        end else begin : g_out
            assign w_pin[g] = 8'h00;
        end
    end

    always_comb begin
        w_match = (r_len == LEN_W'(PIN_DIGITS));
        for (int i = 0; i < PIN_DIGITS; i++) begin
            if (r_buf[i] != w_pin[i]) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_tinc    = r_tcnt + 8'd1;
    assign w_cdec    = (r_cnt != 4'd0) ? r_cnt - 4'd1 : r_cnt;
    assign w_buf_idx = r_len[IDX_W-1:0];

    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_tcnt   = r_tcnt;
        n_run    = r_run;
        n_buzz   = r_buzz;
        n_cnt    = r_cnt;
        w_buf_we = 1'b0;
        w_ev     = EV_NONE;
        unique case (i_item.operation)
            OP_KEY: begin
                if (r_mode == MODE_ENTRY) begin
                    case (i_item.key_code)
                        KEY_ENTER: begin
                            n_len = '0;
                            if (w_match) begin
                                n_run  = 1'b0;
                                n_tcnt = 8'd0;
                                n_buzz = 1'b0;
                                n_mode = MODE_PROMPT;
                                w_ev   = EV_OK;
                            end else begin
                                w_ev = EV_WRONG;
                            end
                        end
                        KEY_DEL: begin
                            if (r_len != '0) begin
                                n_len = r_len - LEN_W'(1);
                            end
                        end
                        default: begin
                            if (r_len < LEN_W'(PIN_DIGITS)) begin
                                w_buf_we = 1'b1;
                                n_len    = r_len + LEN_W'(1);
                            end
                        end
                    endcase
                end else if (r_mode == MODE_PROMPT) begin
                    case (i_item.key_code)
                        KEY_REARM: begin
                            if (i_cfg.rearm_seconds == 4'd0) begin
                                n_mode = MODE_ARMED;
                                w_ev   = EV_ARMED;
                            end else begin
                                n_cnt  = i_cfg.rearm_seconds;
                                n_mode = MODE_COUNT;
                            end
                        end
                        KEY_OFF: begin
                            n_mode = MODE_OFF;
                            w_ev   = EV_SHUTDOWN;
                        end
                        default: ;
                    endcase
                end
            end
            OP_MOTION: begin
                if (r_mode == MODE_ARMED) begin
                    n_mode = MODE_ENTRY;
                    n_len  = '0;
                    n_tcnt = 8'd0;
                    n_run  = 1'b1;
                    w_ev   = EV_MOTION;
                end
            end
            OP_TICK: begin
                if (r_mode == MODE_ENTRY && r_run) begin
                    if (w_tinc >= i_cfg.timeout_seconds) begin
                        n_run  = 1'b0;
                        n_tcnt = 8'd0;
                        n_buzz = 1'b1;
                        w_ev   = EV_ALARM;
                    end else begin
                        n_tcnt = w_tinc;
                    end
                end else if (r_mode == MODE_COUNT) begin
                    n_cnt = w_cdec;
                    if (w_cdec == 4'd0) begin
                        n_mode = MODE_ARMED;
                        w_ev   = EV_ARMED;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.mode           = mode_code(n_mode);
        o_res.buzzer_on      = n_buzz;
        o_res.entered_count  = 3'(n_len);
        o_res.countdown_left = (n_mode == MODE_COUNT) ? n_cnt : 4'd0;
        o_res.event_res      = w_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PROMPT;
            r_len  <= '0;
            r_tcnt <= 8'd0;
            r_run  <= 1'b0;
            r_buzz <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_tcnt <= n_tcnt;
            r_run  <= n_run;
            r_buzz <= n_buzz;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_buf_we) begin
            r_buf[w_buf_idx] <= i_item.key_code;
        end
    end

    `KAC_ASSERT(a_len_bound, r_len <= LEN_W'(PIN_DIGITS), "entry length beyond buffer")
    `KAC_ASSERT(a_run_entry, r_run |-> r_mode == MODE_ENTRY, "timer running outside entry")
    `KAC_ASSERT(a_alarm_buzz, (i_adv && w_ev == EV_ALARM) |=> r_buzz, "alarm without buzzer")

endmodule

// ===== hw/rtl/keypad_alarm_controller.sv =====
// An accepted word is registered; its result is registered and shown at o_out_valid.
// One word per cycle unless the output stalls; the state update is one kac_fsm pass.
// Input register and result register let both sides stall without a bubble.
// Reset (i_rst_n low at a rising edge, synchronous): pipeline empties, mode goes to
// rearm prompt, buzzer, timer and counters clear, registers return to their defaults.
`include "keypad_alarm_controller_defines.svh"

module keypad_alarm_controller #(
    parameter int PIN_DIGITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kac_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_operation,
    input  logic [7:0]                 i_key_code,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [2:0]                 o_mode,
    output logic                       o_buzzer_on,
    output logic [2:0]                 o_entered_count,
    output logic [3:0]                 o_countdown_left,
    output logic [2:0]                 o_event_res
);
    import kac_pkg::*;

    t_cfg  w_cfg;
    t_item r_item;
    t_res  w_res, r_res;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  w_adv;

    kac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kac_fsm #(
        .PIN_DIGITS (PIN_DIGITS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_item  (r_item),
        .i_adv   (w_adv),
        .o_res   (w_res)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.operation <= i_operation;
            r_item.key_code  <= i_key_code;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_res.mode;
    assign o_buzzer_on      = r_res.buzzer_on;
    assign o_entered_count  = r_res.entered_count;
    assign o_countdown_left = r_res.countdown_left;
    assign o_event_res      = r_res.event_res;

    `KAC_ASSERT(a_adv_fills, w_adv |=> r_out_valid, "advanced word not presented")
    `KAC_ASSERT(a_rise_src, $rose(r_out_valid) |-> $past(r_in_valid), "result without source word")
    `KAC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !r_in_valid && !r_out_valid, "pipeline not empty after reset")

endmodule

// ===== test/tb_keypad_alarm_controller.sv =====
`timescale 1ns / 100ps

module tb_keypad_alarm_controller;
    import kac_pkg::*;

    localparam int         PIN_DIGITS   = 4;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         PHASES       = 6;
    localparam int         PHASE_WORDS  = 215;
    localparam int         SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [2:0]      mode;
        logic [3:0][7:0] keys;
        logic [2:0]      len;
        logic [7:0]      secs;
        logic            running;
        logic            buzz;
        logic [3:0]      left;
    } t_alarm_state;

    typedef struct {
        bit          is_reg;
        logic [1:0]  sel;
        logic [31:0] data;
        bit          typed;
        t_res        status;
    } t_plan_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_operation = '0;
    logic [7:0]        i_key_code  = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [2:0]        o_mode;
    logic              o_buzzer_on;
    logic [2:0]        o_entered_count;
    logic [3:0]        o_countdown_left;
    logic [2:0]        o_event_res;

    keypad_alarm_controller #(.PIN_DIGITS(PIN_DIGITS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_key_code       (i_key_code),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mode           (o_mode),
        .o_buzzer_on      (o_buzzer_on),
        .o_entered_count  (o_entered_count),
        .o_countdown_left (o_countdown_left),
        .o_event_res      (o_event_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_alarm_state alarm_st;
    logic [31:0]  pin_reg;
    logic [7:0]   timeout_reg;
    logic [3:0]   rearm_reg;
    t_res         pending_status [$];
    t_plan_row    plan [$];

    int burst_left    = 0;
    int error_count   = 0;
    int status_seen   = 0;
    int words_sent    = 0;
    int words_useful  = 0;
    int alarms        = 0;
    int disarms       = 0;
    int wrong_pins    = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;
    int ready_style   = 0;
    int ready_hold    = 0;
    int ready_phase   = 0;
    logic [7:0] ready_mask = 8'hFF;

    function automatic logic [7:0] pin_char(input int i);
        return pin_reg[8*(PIN_DIGITS-1-i) +: 8];
    endfunction

    function automatic t_res alarm_step(input logic [1:0] op, input logic [7:0] key);
        t_res       r;
        logic [2:0] ev;
        bit         match;
        ev = EV_NONE;
        case (op)
            OP_KEY: begin
                if (alarm_st.mode == MODE_CODE_ENTRY) begin
                    if (key == KEY_ENTER) begin
                        match = (alarm_st.len == PIN_DIGITS);
                        for (int i = 0; i < PIN_DIGITS; i++)
                            if (alarm_st.keys[i] != pin_char(i)) match = 1'b0;
                        alarm_st.len = '0;
                        if (match) begin
                            alarm_st.running = 1'b0;
                            alarm_st.secs    = '0;
                            alarm_st.buzz    = 1'b0;
                            alarm_st.mode    = MODE_CODE_PROMPT;
                            ev = EV_OK;
                        end else begin
                            ev = EV_WRONG;
                        end
                    end else if (key == KEY_DEL) begin
                        if (alarm_st.len != 0) alarm_st.len = alarm_st.len - 3'd1;
                    end else if (alarm_st.len < PIN_DIGITS) begin
                        alarm_st.keys[alarm_st.len] = key;
                        alarm_st.len = alarm_st.len + 3'd1;
                    end
                end else if (alarm_st.mode == MODE_CODE_PROMPT) begin
                    if (key == KEY_REARM) begin
                        if (rearm_reg == 0) begin
                            alarm_st.mode = MODE_CODE_ARMED;
                            ev = EV_ARMED;
                        end else begin
                            alarm_st.left = rearm_reg;
                            alarm_st.mode = MODE_CODE_COUNT;
                        end
                    end else if (key == KEY_OFF) begin
                        alarm_st.mode = MODE_CODE_OFF;
                        ev = EV_SHUTDOWN;
                    end
                end
            end
            OP_MOTION: begin
                if (alarm_st.mode == MODE_CODE_ARMED) begin
                    alarm_st.mode    = MODE_CODE_ENTRY;
                    alarm_st.len     = '0;
                    alarm_st.secs    = '0;
                    alarm_st.running = 1'b1;
                    ev = EV_MOTION;
                end
            end
            OP_TICK: begin
                if (alarm_st.mode == MODE_CODE_ENTRY && alarm_st.running) begin
                    alarm_st.secs = alarm_st.secs + 8'd1;
                    if (alarm_st.secs >= timeout_reg) begin
                        alarm_st.running = 1'b0;
                        alarm_st.secs    = '0;
                        alarm_st.buzz    = 1'b1;
                        ev = EV_ALARM;
                    end
                end else if (alarm_st.mode == MODE_CODE_COUNT) begin
                    if (alarm_st.left != 0) alarm_st.left = alarm_st.left - 4'd1;
                    if (alarm_st.left == 0) begin
                        alarm_st.mode = MODE_CODE_ARMED;
                        ev = EV_ARMED;
                    end
                end
            end
            default: ;
        endcase
        r.mode           = alarm_st.mode;
        r.buzzer_on      = alarm_st.buzz;
        r.entered_count  = alarm_st.len;
        r.countdown_left = (alarm_st.mode == MODE_CODE_COUNT) ? alarm_st.left : 4'd0;
        r.event_res      = ev;
        return r;
    endfunction

    function automatic void pick_word(input bit wind_down, output logic [1:0] op,
                                      output logic [7:0] key);
        int unsigned roll;
        bit          on_track;
        roll = $urandom_range(0, 99);
        op   = OP_KEY;
        key  = 8'($urandom_range(0, 255));
        if (alarm_st.mode == MODE_CODE_OFF || (!wind_down && roll < 18)) begin
            op = 2'($urandom_range(0, 3));
            if (roll < 4) key = KEY_DEL;
            else if (roll < 7) key = KEY_ENTER;
            if (alarm_st.mode == MODE_CODE_PROMPT && key == KEY_OFF) key = KEY_REARM;
            return;
        end
        case (alarm_st.mode)
            MODE_CODE_ARMED:  op = OP_MOTION;
            MODE_CODE_COUNT:  op = OP_TICK;
            MODE_CODE_PROMPT: key = wind_down ? KEY_OFF : KEY_REARM;
            default: begin
                on_track = 1'b1;
                for (int i = 0; i < PIN_DIGITS; i++)
                    if (i < alarm_st.len && alarm_st.keys[i] != pin_char(i)) on_track = 1'b0;
                if (!wind_down && roll < 55) op = OP_TICK;
                else if (!wind_down && roll < 63 && alarm_st.len != 0) key = KEY_DEL;
                else if (!on_track || alarm_st.len == PIN_DIGITS) key = KEY_ENTER;
                else key = pin_char(alarm_st.len);
            end
        endcase
    endfunction

    function automatic logic [31:0] random_pin();
        logic [31:0] p;
        for (int i = 0; i < 4; i++) begin
            do begin
                p[8*i +: 8] = 8'($urandom_range(0, 255));
            end while (p[8*i +: 8] == KEY_ENTER || p[8*i +: 8] == KEY_DEL);
        end
        return p;
    endfunction

    function automatic t_res status_of(input logic [2:0] mode, input logic buzz,
                                       input logic [2:0] cnt, input logic [3:0] left,
                                       input logic [2:0] ev);
        t_res r;
        r.mode           = mode;
        r.buzzer_on      = buzz;
        r.entered_count  = cnt;
        r.countdown_left = left;
        r.event_res      = ev;
        return r;
    endfunction

    function automatic void add_word(input logic [1:0] op, input logic [7:0] key);
        t_plan_row row;
        row.is_reg = 1'b0;
        row.sel    = op;
        row.data   = 32'(key);
        row.typed  = 1'b0;
        row.status = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_checked(input logic [1:0] op, input logic [7:0] key,
                                        input t_res status);
        add_word(op, key);
        plan[$].typed  = 1'b1;
        plan[$].status = status;
    endfunction

    function automatic void add_reg(input logic [1:0] idx, input logic [31:0] val);
        t_plan_row row;
        row.is_reg = 1'b1;
        row.sel    = idx;
        row.data   = val;
        row.typed  = 1'b0;
        row.status = '0;
        plan.push_back(row);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_status(input t_res seen);
        t_res want;
        status_seen++;
        if (pending_status.size() == 0) begin
            note_error($sformatf("unexpected status word mode %0d event %0d",
                                 seen.mode, seen.event_res));
            return;
        end
        want = pending_status.pop_front();
        if (seen.mode !== want.mode || seen.buzzer_on !== want.buzzer_on ||
            seen.entered_count !== want.entered_count ||
            seen.countdown_left !== want.countdown_left ||
            seen.event_res !== want.event_res)
            note_error($sformatf({"status word %0d (expected/actual): mode %0d/%0d ",
                                  "buzzer %0d/%0d count %0d/%0d left %0d/%0d event %0d/%0d"},
                                 status_seen, want.mode, seen.mode, want.buzzer_on,
                                 seen.buzzer_on, want.entered_count, seen.entered_count,
                                 want.countdown_left, seen.countdown_left,
                                 want.event_res, seen.event_res));
    endtask

    task automatic send_word(input logic [1:0] op, input logic [7:0] key);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(8, 30);
                default: gap = $urandom_range(1, 7);
            endcase
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key_code  <= key;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic feed(input logic [1:0] op, input logic [7:0] key);
        t_alarm_state prior;
        t_res         want;
        send_word(op, key);
        prior = alarm_st;
        want  = alarm_step(op, key);
        pending_status.push_back(want);
        words_sent++;
        if (prior != alarm_st || want.event_res != EV_NONE) words_useful++;
        case (want.event_res)
            EV_ALARM: alarms++;
            EV_OK:    disarms++;
            EV_WRONG: wrong_pins++;
            default:  ;
        endcase
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PIN:     pin_reg = val;
            REG_TIMEOUT: timeout_reg = val[7:0];
            REG_REARM:   rearm_reg = val[3:0];
            default:     ;
        endcase
        reg_writes++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_status({o_mode, o_buzzer_on, o_entered_count, o_countdown_left, o_event_res});
        if (ready_hold == 0) begin
            ready_style = $urandom_range(0, 2);
            ready_hold  = $urandom_range(16, 160);
            ready_mask  = 8'($urandom) | 8'h01;
        end else begin
            ready_hold--;
        end
        ready_phase++;
        case (ready_style)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ready_mask[ready_phase[2:0]];
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d status words outstanding",
                     cycle_count, pending_status.size());
            $display("keypad_alarm_controller regression: fail");
            $finish;
        end
    end

    initial begin : run
        logic [31:0] phase_pin     [PHASES];
        logic [7:0]  phase_timeout [PHASES];
        logic [3:0]  phase_rearm   [PHASES];
        logic [1:0]  op;
        logic [7:0]  key;
        int          start;
        int          guard;

        alarm_st      = '0;
        alarm_st.mode = MODE_CODE_PROMPT;
        pin_reg       = PIN_RESET;
        timeout_reg   = TIMEOUT_RESET;
        rearm_reg     = REARM_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_checked(OP_UNUSED, 8'hFF,
                    status_of(MODE_CODE_PROMPT, 1'b0, 3'd0, 4'd0, EV_NONE));
        add_checked(OP_MOTION, 8'h00,
                    status_of(MODE_CODE_PROMPT, 1'b0, 3'd0, 4'd0, EV_NONE));
        add_checked(OP_KEY, KEY_REARM,
                    status_of(MODE_CODE_COUNT, 1'b0, 3'd0, 4'd5, EV_NONE));
        repeat (4) add_word(OP_TICK, 8'h00);
        add_checked(OP_TICK, 8'h00,
                    status_of(MODE_CODE_ARMED, 1'b0, 3'd0, 4'd0, EV_ARMED));
        add_word(OP_KEY, KEY_ENTER);
        add_checked(OP_MOTION, 8'hFF,
                    status_of(MODE_CODE_ENTRY, 1'b0, 3'd0, 4'd0, EV_MOTION));
        add_word(OP_KEY, KEY_DEL);
        add_word(OP_KEY, 8'h31);
        add_word(OP_KEY, 8'h32);
        add_word(OP_KEY, 8'h33);
        add_word(OP_KEY, 8'h34);
        add_checked(OP_KEY, 8'hFF,
                    status_of(MODE_CODE_ENTRY, 1'b0, 3'd4, 4'd0, EV_NONE));
        add_word(OP_KEY, KEY_DEL);
        add_checked(OP_KEY, KEY_ENTER,
                    status_of(MODE_CODE_ENTRY, 1'b0, 3'd0, 4'd0, EV_WRONG));
        add_reg(REG_TIMEOUT, 32'd0);
        add_reg(REG_PIN, 32'h0000_0000);
        add_checked(OP_TICK, 8'h00,
                    status_of(MODE_CODE_ENTRY, 1'b1, 3'd0, 4'd0, EV_ALARM));
        repeat (4) add_word(OP_KEY, 8'h00);
        add_checked(OP_KEY, KEY_ENTER,
                    status_of(MODE_CODE_PROMPT, 1'b0, 3'd0, 4'd0, EV_OK));
        add_reg(REG_REARM, 32'd0);
        add_checked(OP_KEY, KEY_REARM,
                    status_of(MODE_CODE_ARMED, 1'b0, 3'd0, 4'd0, EV_ARMED));

        foreach (plan[n]) begin
            if (plan[n].is_reg) begin
                settle();
                write_reg(plan[n].sel, plan[n].data);
            end else begin
                feed(plan[n].sel, plan[n].data[7:0]);
                if (plan[n].typed) pending_status[$] = plan[n].status;
            end
        end

        phase_pin     = '{random_pin(), 32'hFFFF_FFFF, random_pin(), random_pin(),
                          random_pin(), PIN_RESET};
        phase_timeout = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(1, 8)),
                          8'($urandom_range(2, 20)), TIMEOUT_RESET};
        phase_rearm   = '{4'd15, 4'd1, 4'd0, 4'($urandom_range(1, 4)),
                          4'($urandom_range(0, 15)), REARM_RESET};

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_reg(REG_PIN, phase_pin[ph]);
            write_reg(REG_TIMEOUT, 32'(phase_timeout[ph]));
            write_reg(REG_REARM, 32'(phase_rearm[ph]));
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                pick_word(1'b0, op, key);
                feed(op, key);
            end
        end

        // walk to the prompt, shut down, then poke the dead block
        guard = 0;
        while (alarm_st.mode != MODE_CODE_OFF && guard < 400) begin
            pick_word(1'b1, op, key);
            feed(op, key);
            guard++;
        end
        repeat (12) begin
            pick_word(1'b1, op, key);
            feed(op, key);
        end

        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d words sent (%0d with effect), %0d register writes, %0d status words checked",
                 words_sent, words_useful, reg_writes, status_seen);
        $display("%0d alarms, %0d accepted pins, %0d wrong pins, %0d mismatches",
                 alarms, disarms, wrong_pins, error_count);
        if (error_count == 0) begin
            $display("keypad_alarm_controller regression: pass");
        end else begin
            $display("keypad_alarm_controller regression: fail");
        end
        $finish;
    end

endmodule
